// ----- src/tmpe_pkg.sv -----
// tmpe_pkg: widths, codes, shared types and saturation helpers of the
// trapezoid motion profile evaluator; no dependencies
`default_nettype none

package tmpe_pkg;

	function automatic int max2(input int x, input int y);
		return (x > y) ? x : y;
	endfunction

	// field widths
	localparam int TIME_BITS = 24;
	localparam int POS_W     = 64;
	localparam int VEL_W     = 48;
	localparam int A_W       = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	// multiplier split: 48-bit operands go in as two 24-bit halves
	localparam int AH_W  = A_W / 2;
	localparam int SQ_W  = 2 * TIME_BITS;
	localparam int PH_W  = AH_W + TIME_BITS + 1;
	localparam int PL_W  = AH_W + TIME_BITS;
	localparam int AU_W  = A_W + TIME_BITS + 1;
	localparam int ASQ_W = A_W + SQ_W + 1;

	// velocity sums are q48, position sums q49, both rounded to q32
	localparam int VSH   = 16;
	localparam int PSH   = 17;
	localparam int VS_W  = max2(VEL_W + VSH, AU_W) + 2;
	localparam int PS_W  = max2(max2(POS_W + PSH, AU_W + PSH), ASQ_W) + 2;
	localparam int VSS_W = VS_W - VSH;
	localparam int PSS_W = PS_W - PSH;

	localparam logic signed [VS_W-1:0] VRND = VS_W'(1) << (VSH - 1);
	localparam logic signed [PS_W-1:0] PRND = PS_W'(1) << (PSH - 1);

	// phase codes
	localparam logic [1:0] PH_ACCEL  = 2'd0;
	localparam logic [1:0] PH_CRUISE = 2'd1;
	localparam logic [1:0] PH_DECEL  = 2'd2;

	// item kinds traveling down the pipe
	localparam logic [1:0] KIND_USER   = 2'd0;
	localparam logic [1:0] KIND_CRUISE = 2'd1;
	localparam logic [1:0] KIND_CORNER = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_POS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_VEL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_END   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL_START = 3'd4;

	typedef struct packed {
		logic       vld;
		logic [1:0] kind;
		logic [1:0] phase;
	} tmpe_ctl_t;

	typedef struct packed {
		logic [POS_W-1:0]     p0;
		logic [VEL_W-1:0]     v0;
		logic [A_W-1:0]       a;
		logic [TIME_BITS-1:0] t1;
		logic [TIME_BITS-1:0] t2;
		logic [VEL_W-1:0]     f;
		logic [POS_W-1:0]     s1;
		logic [POS_W-1:0]     s2;
	} tmpe_cfg_t;

	function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VSS_W-1:0] x);
		logic [VSS_W-VEL_W:0] head;
		head = x[VSS_W-1:VEL_W-1];
		if ((&head) || !(|head))
			return x[VEL_W-1:0];
		else if (x[VSS_W-1])
			return {1'b1, {(VEL_W-1){1'b0}}};
		else
			return {1'b0, {(VEL_W-1){1'b1}}};
	endfunction

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [PSS_W-1:0] x);
		logic [PSS_W-POS_W:0] head;
		head = x[PSS_W-1:POS_W-1];
		if ((&head) || !(|head))
			return x[POS_W-1:0];
		else if (x[PSS_W-1])
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return {1'b0, {(POS_W-1){1'b1}}};
	endfunction

endpackage

`default_nettype wire

// ----- src/tmpe_front.sv -----
// tmpe_front: stage 1, phase decision and operand selection
// depends on tmpe_pkg
`default_nettype none

module tmpe_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           in_vld,
	input  logic [1:0]                     in_kind,
	input  logic [tmpe_pkg::TIME_BITS-1:0] sample_time,
	input  tmpe_pkg::tmpe_cfg_t            cfg,
	output tmpe_pkg::tmpe_ctl_t            ctl_s1,
	output logic [tmpe_pkg::TIME_BITS-1:0] u_s1,
	output logic [tmpe_pkg::VEL_W-1:0]     v_s1,
	output logic [tmpe_pkg::POS_W-1:0]     p_s1
);
	import tmpe_pkg::*;

	logic [TIME_BITS-1:0] t2e;
	logic [1:0]           phase_d;
	logic [TIME_BITS-1:0] u_d;
	logic [VEL_W-1:0]     v_d;
	logic [POS_W-1:0]     p_d;

	// decel start below accel end means no cruise phase
	assign t2e = (cfg.t2 < cfg.t1) ? cfg.t1 : cfg.t2;

	always_comb begin
		case (in_kind)
			KIND_CRUISE: begin
				phase_d = PH_ACCEL;
				u_d     = cfg.t1;
				v_d     = cfg.v0;
				p_d     = cfg.p0;
			end
			KIND_CORNER: begin
				phase_d = PH_CRUISE;
				u_d     = t2e - cfg.t1;
				v_d     = cfg.f;
				p_d     = cfg.s1;
			end
			default: begin
				if (sample_time < cfg.t1) begin
					phase_d = PH_ACCEL;
					u_d     = sample_time;
					v_d     = cfg.v0;
					p_d     = cfg.p0;
				end else if (sample_time < t2e) begin
					phase_d = PH_CRUISE;
					u_d     = sample_time - cfg.t1;
					v_d     = cfg.f;
					p_d     = cfg.s1;
				end else begin
					phase_d = PH_DECEL;
					u_d     = sample_time - t2e;
					v_d     = cfg.f;
					p_d     = cfg.s2;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld   <= in_vld;
			ctl_s1.kind  <= in_kind;
			ctl_s1.phase <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= u_d;
			v_s1 <= v_d;
			p_s1 <= p_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/tmpe_mul.sv -----
// tmpe_mul: stages 2 and 3, partial products of a*u, v*u, u*u and a*u*u
// depends on tmpe_pkg
`default_nettype none

module tmpe_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [tmpe_pkg::A_W-1:0]       a,
	input  tmpe_pkg::tmpe_ctl_t            ctl_s1,
	input  logic [tmpe_pkg::TIME_BITS-1:0] u_s1,
	input  logic [tmpe_pkg::VEL_W-1:0]     v_s1,
	input  logic [tmpe_pkg::POS_W-1:0]     p_s1,
	output tmpe_pkg::tmpe_ctl_t            ctl_s3,
	output logic [tmpe_pkg::VEL_W-1:0]     v_s3,
	output logic [tmpe_pkg::POS_W-1:0]     p_s3,
	output logic signed [tmpe_pkg::AU_W-1:0] au_s3,
	output logic signed [tmpe_pkg::AU_W-1:0] vu_s3,
	output logic signed [tmpe_pkg::PH_W-1:0] qhh_s3,
	output logic signed [tmpe_pkg::PH_W-1:0] qhl_s3,
	output logic [tmpe_pkg::PL_W-1:0]        qlh_s3,
	output logic [tmpe_pkg::PL_W-1:0]        qll_s3
);
	import tmpe_pkg::*;

	logic signed [AH_W-1:0]      ah;
	logic [AH_W-1:0]             al;
	logic signed [AH_W-1:0]      vh;
	logic [AH_W-1:0]             vl;
	logic signed [TIME_BITS:0]   uz;

	tmpe_ctl_t                   ctl_s2;
	logic [VEL_W-1:0]            v_s2;
	logic [POS_W-1:0]            p_s2;
	logic signed [PH_W-1:0]      pah_s2;
	logic [PL_W-1:0]             pal_s2;
	logic signed [PH_W-1:0]      pvh_s2;
	logic [PL_W-1:0]             pvl_s2;
	logic [SQ_W-1:0]             sq_s2;

	logic [TIME_BITS-1:0]        sq_hi;
	logic [TIME_BITS-1:0]        sq_lo;
	logic signed [TIME_BITS:0]   sq_hi_z;
	logic signed [TIME_BITS:0]   sq_lo_z;

	assign ah      = $signed(a[A_W-1:AH_W]);
	assign al      = a[AH_W-1:0];
	assign vh      = $signed(v_s1[VEL_W-1:AH_W]);
	assign vl      = v_s1[AH_W-1:0];
	assign uz      = $signed({1'b0, u_s1});
	assign sq_hi   = sq_s2[SQ_W-1:TIME_BITS];
	assign sq_lo   = sq_s2[TIME_BITS-1:0];
	assign sq_hi_z = $signed({1'b0, sq_hi});
	assign sq_lo_z = $signed({1'b0, sq_lo});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 2: one row of 24-bit products
			v_s2   <= v_s1;
			p_s2   <= p_s1;
			pah_s2 <= ah * uz;
			pal_s2 <= al * u_s1;
			pvh_s2 <= vh * uz;
			pvl_s2 <= vl * u_s1;
			sq_s2  <= u_s1 * u_s1;
			// stage 3: fold the u products, start a*u*u
			v_s3   <= v_s2;
			p_s3   <= p_s2;
			au_s3  <= (AU_W'(pah_s2) <<< AH_W) + $signed(AU_W'(pal_s2));
			vu_s3  <= (AU_W'(pvh_s2) <<< AH_W) + $signed(AU_W'(pvl_s2));
			qhh_s3 <= ah * sq_hi_z;
			qhl_s3 <= ah * sq_lo_z;
			qlh_s3 <= al * sq_hi;
			qll_s3 <= al * sq_lo;
		end
	end

endmodule

`default_nettype wire

// ----- src/tmpe_sum.sv -----
// tmpe_sum: stages 4 and 5, term sums, rounding and velocity saturation
// depends on tmpe_pkg
`default_nettype none

module tmpe_sum (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  tmpe_pkg::tmpe_ctl_t              ctl_s3,
	input  logic [tmpe_pkg::VEL_W-1:0]       v_s3,
	input  logic [tmpe_pkg::POS_W-1:0]       p_s3,
	input  logic signed [tmpe_pkg::AU_W-1:0] au_s3,
	input  logic signed [tmpe_pkg::AU_W-1:0] vu_s3,
	input  logic signed [tmpe_pkg::PH_W-1:0] qhh_s3,
	input  logic signed [tmpe_pkg::PH_W-1:0] qhl_s3,
	input  logic [tmpe_pkg::PL_W-1:0]        qlh_s3,
	input  logic [tmpe_pkg::PL_W-1:0]        qll_s3,
	output tmpe_pkg::tmpe_ctl_t              ctl_s5,
	output logic [tmpe_pkg::VEL_W-1:0]       vel_s5,
	output logic signed [tmpe_pkg::PSS_W-1:0] pos_sh_s5
);
	import tmpe_pkg::*;

	tmpe_ctl_t               ctl_s4;
	logic signed [VS_W-1:0]  vel_w_s4;
	logic signed [PS_W-1:0]  part_s4;
	logic signed [ASQ_W-1:0] asq_s4;

	logic signed [VS_W-1:0]  au_ext;
	logic signed [VS_W-1:0]  au_term;
	logic signed [ASQ_W-1:0] asq_d;
	logic signed [PS_W-1:0]  asq_ext;
	logic signed [PS_W-1:0]  asq_term;
	logic signed [PS_W-1:0]  pos_w;

	// acceleration term: added while accelerating, dropped while cruising,
	// subtracted while decelerating
	assign au_ext = VS_W'(au_s3);

	always_comb begin
		case (ctl_s3.phase)
			PH_ACCEL: au_term = au_ext;
			PH_DECEL: au_term = -au_ext;
			default:  au_term = '0;
		endcase
	end

	assign asq_d = (ASQ_W'(qhh_s3) <<< (AH_W + TIME_BITS))
	             + (ASQ_W'(qhl_s3) <<< AH_W)
	             + ($signed(ASQ_W'(qlh_s3)) <<< TIME_BITS)
	             + $signed(ASQ_W'(qll_s3));

	assign asq_ext = PS_W'(asq_s4);

	always_comb begin
		case (ctl_s4.phase)
			PH_ACCEL: asq_term = asq_ext;
			PH_DECEL: asq_term = -asq_ext;
			default:  asq_term = '0;
		endcase
	end

	assign pos_w = part_s4 + asq_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vel_w_s4  <= (VS_W'($signed(v_s3)) <<< VSH) + au_term + VRND;
			part_s4   <= (PS_W'($signed(p_s3)) <<< PSH) + (PS_W'(vu_s3) <<< PSH) + PRND;
			asq_s4    <= asq_d;
			vel_s5    <= sat_vel(vel_w_s4[VS_W-1:VSH]);
			pos_sh_s5 <= pos_w[PS_W-1:PSH];
		end
	end

endmodule

`default_nettype wire

// ----- src/trapezoid_motion_profile_eval.sv -----
// trapezoid_motion_profile_eval: top level, configuration registers,
// derivation sequencer and output register; uses tmpe_pkg, tmpe_front,
// tmpe_mul and tmpe_sum
`default_nettype none

// Evaluates a trapezoidal move at a sample time: one beat in gives the
// velocity (q32 per tick, saturating), position (q32, saturating) and phase.
// The datapath is a six-stage pipeline (phase select, two product stages,
// two sum stages, output register), so a new sample can be taken every
// cycle while the output is not stalled and no derivation is running;
// a stall on the output holds the whole pipe. Each accepted write to a known
// register rederives the cruise velocity and both corner positions by
// sending two internal items through the same pipeline, one after the
// other; cfg_ready and in_ready stay low until that is done. Writes to
// unknown indexes are taken and ignored.

module trapezoid_motion_profile_eval (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tmpe_pkg::TIME_BITS-1:0] sample_time,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tmpe_pkg::VEL_W-1:0]     velocity,
	output logic [tmpe_pkg::POS_W-1:0]     position,
	output logic [1:0]                     phase,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tmpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tmpe_pkg::CFG_DAT_W-1:0] cfg_data
);
	import tmpe_pkg::*;

	// derivation sequencer codes
	localparam logic [2:0] SEQ_IDLE  = 3'd0;
	localparam logic [2:0] SEQ_INJ1  = 3'd1;
	localparam logic [2:0] SEQ_WAIT1 = 3'd2;
	localparam logic [2:0] SEQ_INJ2  = 3'd3;
	localparam logic [2:0] SEQ_WAIT2 = 3'd4;

	logic [2:0]           seq_q;

	// programmed registers and derived corner values
	logic [POS_W-1:0]     p0_q;
	logic [VEL_W-1:0]     v0_q;
	logic [A_W-1:0]       a_q;
	logic [TIME_BITS-1:0] t1_q;
	logic [TIME_BITS-1:0] t2_q;
	logic [VEL_W-1:0]     f_q;
	logic [POS_W-1:0]     s1_q;
	logic [POS_W-1:0]     s2_q;

	// output register
	logic                 out_valid_q;
	logic [VEL_W-1:0]     vel_q;
	logic [POS_W-1:0]     pos_q;
	logic [1:0]           phase_q;

	tmpe_cfg_t            cfg;
	logic                 adv;
	logic                 cfg_fire;
	logic                 cfg_known;
	logic                 inj;
	logic                 front_vld;
	logic [1:0]           front_kind;
	logic                 cruise_done;
	logic                 corner_done;
	logic [POS_W-1:0]     pos_sat;

	tmpe_ctl_t            ctl_s1;
	logic [TIME_BITS-1:0] u_s1;
	logic [VEL_W-1:0]     v_s1;
	logic [POS_W-1:0]     p_s1;
	tmpe_ctl_t            ctl_s3;
	logic [VEL_W-1:0]     v_s3;
	logic [POS_W-1:0]     p_s3;
	logic signed [AU_W-1:0] au_s3;
	logic signed [AU_W-1:0] vu_s3;
	logic signed [PH_W-1:0] qhh_s3;
	logic signed [PH_W-1:0] qhl_s3;
	logic [PL_W-1:0]      qlh_s3;
	logic [PL_W-1:0]      qll_s3;
	tmpe_ctl_t            ctl_s5;
	logic [VEL_W-1:0]     vel_s5;
	logic signed [PSS_W-1:0] pos_sh_s5;

	// whole pipe moves whenever the output register can take a beat
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv && (seq_q == SEQ_IDLE);
	assign cfg_ready = (seq_q == SEQ_IDLE);
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_comb begin
		case (cfg_index)
			REG_START_POS, REG_START_VEL, REG_ACCEL_RATE,
			REG_ACCEL_END, REG_DECEL_START: cfg_known = 1'b1;
			default:                        cfg_known = 1'b0;
		endcase
	end

	// internal items: the first yields cruise velocity and accel end
	// position, the second the decel start position
	assign inj        = adv && ((seq_q == SEQ_INJ1) || (seq_q == SEQ_INJ2));
	assign front_vld  = (in_valid && in_ready) || inj;
	assign front_kind = !inj ? KIND_USER : ((seq_q == SEQ_INJ1) ? KIND_CRUISE : KIND_CORNER);

	assign cruise_done = adv && ctl_s5.vld && (ctl_s5.kind == KIND_CRUISE);
	assign corner_done = adv && ctl_s5.vld && (ctl_s5.kind == KIND_CORNER);

	assign cfg.p0 = p0_q;
	assign cfg.v0 = v0_q;
	assign cfg.a  = a_q;
	assign cfg.t1 = t1_q;
	assign cfg.t2 = t2_q;
	assign cfg.f  = f_q;
	assign cfg.s1 = s1_q;
	assign cfg.s2 = s2_q;

	tmpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_vld      (front_vld),
		.in_kind     (front_kind),
		.sample_time (sample_time),
		.cfg         (cfg),
		.ctl_s1      (ctl_s1),
		.u_s1        (u_s1),
		.v_s1        (v_s1),
		.p_s1        (p_s1)
	);

	tmpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.a      (a_q),
		.ctl_s1 (ctl_s1),
		.u_s1   (u_s1),
		.v_s1   (v_s1),
		.p_s1   (p_s1),
		.ctl_s3 (ctl_s3),
		.v_s3   (v_s3),
		.p_s3   (p_s3),
		.au_s3  (au_s3),
		.vu_s3  (vu_s3),
		.qhh_s3 (qhh_s3),
		.qhl_s3 (qhl_s3),
		.qlh_s3 (qlh_s3),
		.qll_s3 (qll_s3)
	);

	tmpe_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_s3    (ctl_s3),
		.v_s3      (v_s3),
		.p_s3      (p_s3),
		.au_s3     (au_s3),
		.vu_s3     (vu_s3),
		.qhh_s3    (qhh_s3),
		.qhl_s3    (qhl_s3),
		.qlh_s3    (qlh_s3),
		.qll_s3    (qll_s3),
		.ctl_s5    (ctl_s5),
		.vel_s5    (vel_s5),
		.pos_sh_s5 (pos_sh_s5)
	);

	// final position rounding is already in the sum, only saturation left
	assign pos_sat = sat_pos(pos_sh_s5);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			case (seq_q)
				SEQ_IDLE:  if (cfg_fire && cfg_known) seq_q <= SEQ_INJ1;
				SEQ_INJ1:  if (adv) seq_q <= SEQ_WAIT1;
				SEQ_WAIT1: if (cruise_done) seq_q <= SEQ_INJ2;
				SEQ_INJ2:  if (adv) seq_q <= SEQ_WAIT2;
				SEQ_WAIT2: if (corner_done) seq_q <= SEQ_IDLE;
				default:   seq_q <= SEQ_IDLE;
			endcase
		end
	end

	// configuration and derived state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q <= '0;
			v0_q <= '0;
			a_q  <= '0;
			t1_q <= '0;
			t2_q <= '0;
			f_q  <= '0;
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			if (cfg_fire) begin
				case (cfg_index)
					REG_START_POS:   p0_q <= cfg_data;
					REG_START_VEL:   v0_q <= cfg_data[VEL_W-1:0];
					REG_ACCEL_RATE:  a_q  <= cfg_data[A_W-1:0];
					REG_ACCEL_END:   t1_q <= cfg_data[TIME_BITS-1:0];
					REG_DECEL_START: t2_q <= cfg_data[TIME_BITS-1:0];
					default: ;
				endcase
			end
			if (cruise_done) begin
				f_q  <= vel_s5;
				s1_q <= pos_sat;
			end
			if (corner_done) begin
				s2_q <= pos_sat;
			end
		end
	end

	// output register, internal items never show up here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_s5.vld && (ctl_s5.kind == KIND_USER);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vel_q   <= vel_s5;
			pos_q   <= pos_sat;
			phase_q <= ctl_s5.phase;
		end
	end

	assign out_valid = out_valid_q;
	assign velocity  = vel_q;
	assign position  = pos_q;
	assign phase     = phase_q;

endmodule

`default_nettype wire

// ----- tb/trapezoid_motion_profile_eval_tb.sv -----
// trapezoid_motion_profile_eval_tb: self-checking bench for the trapezoid motion profile evaluator
// drives sample beats and register writes, predicts untyped results in 128-bit exact arithmetic
// depends on tmpe_pkg and trapezoid_motion_profile_eval
`timescale 1ns / 1ps

module trapezoid_motion_profile_eval_tb;
	import tmpe_pkg::*;

	// pipe depth of the block, used for the settle time at the end
	localparam int PIPE_DEPTH  = 6;
	localparam int QUIET_LIMIT = 4000;
	localparam int BUSY_PCT    = 71;
	localparam int BOTH_PCT    = 18;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 64;

	// indexes that map to no register, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;
	typedef logic signed [127:0] acc_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] at;
		logic [VEL_W-1:0]     vel;
		logic [POS_W-1:0]     pos;
		logic [1:0]           ph;
	} profile_pt_t;

	typedef struct {
		bit                   is_wr;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] data;
		logic [TIME_BITS-1:0] t;
		bit                   typed;
		profile_pt_t          want;
	} table_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [TIME_BITS-1:0] sample_time;
	logic                 out_valid;
	logic                 out_ready;
	logic [VEL_W-1:0]     velocity;
	logic [POS_W-1:0]     position;
	logic [1:0]           phase;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	trapezoid_motion_profile_eval dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_time (sample_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.velocity    (velocity),
		.position    (position),
		.phase       (phase),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// bench copy of the move: registers as the block should hold them
	logic signed [POS_W-1:0] mv_p0;
	logic signed [VEL_W-1:0] mv_v0;
	logic signed [A_W-1:0]   mv_a;
	logic [TIME_BITS-1:0]    mv_t1;
	logic [TIME_BITS-1:0]    mv_t2;
	// derived corners: cruise velocity, position at accel end and at decel start
	logic signed [VEL_W-1:0] mv_cruise;
	logic signed [POS_W-1:0] mv_corner1;
	logic signed [POS_W-1:0] mv_corner2;

	profile_pt_t expected_pts[$];
	table_row_t  dir_rows[$];
	idle_mode_t  idle_mode;
	int          err_cnt;
	int          quiet_cycles;
	int          hold_reqs;
	int          hold_seen;
	int          hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// profile arithmetic, every term exact in 128 bits
	// ---------------------------------------------------------------

	// signed term times an unsigned tick count
	function automatic acc_t times_u(input acc_t s, input logic [63:0] u);
		acc_t uw;
		uw = {64'd0, u};
		return s * uw;
	endfunction

	// add half an lsb, then arithmetic shift: round half toward plus infinity
	function automatic acc_t round_at(input acc_t x, input int sh);
		return (x + (acc_t'(1) <<< (sh - 1))) >>> sh;
	endfunction

	// clamp into a signed range of width w, low 64 bits returned
	function automatic logic [63:0] clamp_to(input acc_t x, input int w);
		acc_t top;
		acc_t bot;
		top = (acc_t'(1) <<< (w - 1)) - 1;
		bot = -(acc_t'(1) <<< (w - 1));
		if (x > top)
			x = top;
		else if (x < bot)
			x = bot;
		return x[63:0];
	endfunction

	// decel start never sits below accel end
	function automatic logic [TIME_BITS-1:0] eff_decel_start();
		return (mv_t2 < mv_t1) ? mv_t1 : mv_t2;
	endfunction

	// v0 + a*t, formed in q48
	function automatic logic [VEL_W-1:0] accel_vel_at(input logic [TIME_BITS-1:0] t);
		acc_t x;
		x = (acc_t'(mv_v0) <<< 16) + times_u(mv_a, 64'(t));
		return VEL_W'(clamp_to(round_at(x, 16), VEL_W));
	endfunction

	// p0 + v0*t + a*t*t/2, formed in q49 so the half is exact
	function automatic logic [POS_W-1:0] accel_pos_at(input logic [TIME_BITS-1:0] t);
		acc_t        x;
		logic [63:0] tw;
		tw = 64'(t);
		x = (acc_t'(mv_p0) <<< 17) + (times_u(mv_v0, tw) <<< 17) + times_u(mv_a, tw * tw);
		return clamp_to(round_at(x, 17), POS_W);
	endfunction

	// corners are rebuilt on every write to a mapped register
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] d);
		logic [TIME_BITS-1:0] t2e;
		case (idx)
			REG_START_POS:   mv_p0 = d;
			REG_START_VEL:   mv_v0 = d[VEL_W-1:0];
			REG_ACCEL_RATE:  mv_a  = d[A_W-1:0];
			REG_ACCEL_END:   mv_t1 = d[TIME_BITS-1:0];
			REG_DECEL_START: mv_t2 = d[TIME_BITS-1:0];
			default:         return;
		endcase
		t2e = eff_decel_start();
		mv_cruise  = accel_vel_at(mv_t1);
		mv_corner1 = accel_pos_at(mv_t1);
		mv_corner2 = clamp_to(acc_t'(mv_corner1) +
			times_u(mv_cruise, 64'(t2e) - 64'(mv_t1)), POS_W);
	endfunction

	function automatic profile_pt_t profile_at(input logic [TIME_BITS-1:0] t);
		profile_pt_t          pt;
		logic [TIME_BITS-1:0] t2e;
		logic [63:0]          dt;
		acc_t                 v;
		acc_t                 p;
		t2e = eff_decel_start();
		pt.at = t;
		if (t < mv_t1) begin
			pt.vel = accel_vel_at(t);
			pt.pos = accel_pos_at(t);
			pt.ph  = PH_ACCEL;
		end else if (t < t2e) begin
			// linear from the first corner at cruise velocity
			pt.vel = mv_cruise;
			pt.pos = clamp_to(acc_t'(mv_corner1) +
				times_u(mv_cruise, 64'(t) - 64'(mv_t1)), POS_W);
			pt.ph  = PH_CRUISE;
		end else begin
			// parabola from the second corner, slope falling at -a
			dt = 64'(t) - 64'(t2e);
			v = (acc_t'(mv_cruise) <<< 16) - times_u(mv_a, dt);
			p = (acc_t'(mv_corner2) <<< 17) + (times_u(mv_cruise, dt) <<< 17) -
				times_u(mv_a, dt * dt);
			pt.vel = VEL_W'(clamp_to(round_at(v, 16), VEL_W));
			pt.pos = clamp_to(round_at(p, 17), POS_W);
			pt.ph  = PH_DECEL;
		end
		return pt;
	endfunction

	// ---------------------------------------------------------------
	// random values
	// ---------------------------------------------------------------

	// signed register value: extremes, full random, or a modest sw-bit value;
	// bits above w are junk that the block must mask
	function automatic logic [63:0] rand_wide(input int w, input int sw);
		logic [63:0] r;
		logic [63:0] junk;
		r = {$urandom, $urandom};
		junk = {$urandom, $urandom} << w;
		case ($urandom_range(0, 7))
			0:       return ((64'd1 << (w - 1)) - 64'd1) | junk;
			1:       return (64'd1 << (w - 1)) | junk;
			2:       return r;
			default: return 64'($signed(r) >>> (64 - sw));
		endcase
	endfunction

	function automatic logic [63:0] rand_reg_data(input logic [CFG_IDX_W-1:0] idx);
		case (idx)
			REG_START_POS:                  return rand_wide(POS_W, 40);
			REG_START_VEL, REG_ACCEL_RATE:  return rand_wide(VEL_W, 38);
			REG_ACCEL_END, REG_DECEL_START: begin
				case ($urandom_range(0, 9))
					0:       return {$urandom, $urandom};
					1:       return 64'hff_ffff;
					2:       return 64'd0;
					default: return 64'($urandom_range(0, 1500));
				endcase
			end
			default:                        return {$urandom, $urandom};
		endcase
	endfunction

	// mostly inside the move, often right on a corner, sometimes anywhere
	function automatic logic [TIME_BITS-1:0] pick_time();
		logic [TIME_BITS-1:0] t2e;
		t2e = eff_decel_start();
		case ($urandom_range(0, 9))
			0:       return TIME_BITS'($urandom);
			1:       return mv_t1 + TIME_BITS'($urandom_range(0, 2)) - 1'b1;
			2:       return t2e + TIME_BITS'($urandom_range(0, 2)) - 1'b1;
			default: return TIME_BITS'($urandom_range(0, int'(t2e) + 200));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// directed table rows
	// ---------------------------------------------------------------

	function automatic table_row_t wr_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] d);
		table_row_t r;
		r = '{is_wr: 1'b1, idx: idx, data: d, t: '0, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic table_row_t smp_row(input logic [TIME_BITS-1:0] t);
		table_row_t r;
		r = '{is_wr: 1'b0, idx: '0, data: '0, t: t, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic table_row_t typed_row(input logic [TIME_BITS-1:0] t,
			input logic [VEL_W-1:0] v, input logic [POS_W-1:0] p, input logic [1:0] ph);
		table_row_t r;
		r = smp_row(t);
		r.typed = 1'b1;
		r.want = '{at: t, vel: v, pos: p, ph: ph};
		return r;
	endfunction

	// append one row at the end of the table
	function automatic void add_row(input table_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [TIME_BITS-1:0] at,
			input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s at t=%0d: got %h want %h", what, at, got, want);
		err_cnt++;
	endtask

	// compare each result beat with the oldest expected point
	always @(posedge clk) begin : out_check
		profile_pt_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pts.size() == 0) begin
				report_mismatch("unexpected beat", '0, position, '0);
			end else begin
				want = expected_pts.pop_front();
				if (velocity !== want.vel)
					report_mismatch("velocity", want.at, 64'(velocity), 64'(want.vel));
				if (position !== want.pos)
					report_mismatch("position", want.at, position, want.pos);
				if (phase !== want.ph)
					report_mismatch("phase", want.at, 64'(phase), 64'(want.ph));
			end
		end
	end

	// watchdog: any accepted beat on any channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver: long hold-off on request, otherwise random stalls per mode
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (idle_mode == IDLE_SNK) begin
			out_ready <= ($urandom_range(0, 99) >= BUSY_PCT);
		end else if (idle_mode == IDLE_BOTH) begin
			out_ready <= ($urandom_range(0, 99) >= BOTH_PCT);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// one sample beat; valid stays up afterwards so back-to-back beats need no gap
	task automatic push_sample(input logic [TIME_BITS-1:0] t, input bit typed,
			input profile_pt_t want);
		int gap;
		int pct;
		gap = 0;
		pct = (idle_mode == IDLE_SRC) ? BUSY_PCT : (idle_mode == IDLE_BOTH) ? BOTH_PCT : 0;
		while (gap < 50 && $urandom_range(0, 99) < pct)
			gap++;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_time <= t;
		do @(posedge clk); while (!in_ready);
		// registers are stable while samples flow, so predict at acceptance
		expected_pts.insert(expected_pts.size(), typed ? want : profile_at(t));
	endtask

	// register write only with the pipe empty; cfg_valid stays up for the next write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
		in_valid <= 1'b0;
		while (expected_pts.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
	endtask

	initial begin
		int                   n;
		logic [CFG_IDX_W-1:0] idx;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample_time  = '0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		idle_mode    = IDLE_NONE;
		err_cnt      = 0;
		quiet_cycles = 0;
		hold_reqs    = 0;
		hold_seen    = 0;
		hold_left    = 0;
		mv_p0 = '0; mv_v0 = '0; mv_a = '0; mv_t1 = '0; mv_t2 = '0;
		mv_cruise = '0; mv_corner1 = '0; mv_corner2 = '0;

		// after reset everything is zero: decel phase from t=0, no motion
		add_row(typed_row(24'd0, '0, '0, PH_DECEL));
		add_row(typed_row(24'hff_ffff, '0, '0, PH_DECEL));
		// largest start position with no motion reads straight back
		add_row(wr_row(REG_START_POS, 64'h7fff_ffff_ffff_ffff));
		add_row(typed_row(24'd0, '0, 64'h7fff_ffff_ffff_ffff, PH_DECEL));
		// unmapped index must change nothing
		add_row(wr_row(REG_UNMAPPED_A, 64'hdead_beef_0123_4567));
		add_row(typed_row(24'd77, '0, 64'h7fff_ffff_ffff_ffff, PH_DECEL));
		// top speed from the top position, position pinned; junk above the time bits
		add_row(wr_row(REG_START_VEL, 64'h0000_7fff_ffff_ffff));
		add_row(wr_row(REG_ACCEL_END, 64'hffff_ffff_ff00_000a));
		add_row(wr_row(REG_DECEL_START, 64'd20));
		// both corners, the tick before each and the tick after the second
		add_row(smp_row(24'd0));
		add_row(smp_row(24'd9));
		add_row(smp_row(24'd10));
		add_row(smp_row(24'd19));
		add_row(smp_row(24'd20));
		add_row(smp_row(24'd21));
		// most negative start, largest accel, decel start below accel end
		add_row(wr_row(REG_START_POS, 64'h8000_0000_0000_0000));
		add_row(wr_row(REG_START_VEL, 64'hffff_8000_0000_0000));
		add_row(wr_row(REG_ACCEL_RATE, 64'h0000_7fff_ffff_ffff));
		add_row(wr_row(REG_ACCEL_END, 64'd1000));
		add_row(wr_row(REG_DECEL_START, 64'd500));
		add_row(smp_row(24'd0));
		add_row(smp_row(24'd999));
		add_row(smp_row(24'd1000));
		add_row(smp_row(24'd1001));
		add_row(smp_row(24'hff_ffff));
		// most negative accel, top speed, corners at the end of the time range
		add_row(wr_row(REG_ACCEL_RATE, 64'hffff_8000_0000_0000));
		add_row(wr_row(REG_START_VEL, 64'h0000_7fff_ffff_ffff));
		add_row(wr_row(REG_ACCEL_END, 64'hff_ffff));
		add_row(wr_row(REG_DECEL_START, 64'hff_ffff));
		add_row(smp_row(24'd0));
		add_row(smp_row(24'hff_fffe));
		add_row(smp_row(24'hff_ffff));
		add_row(wr_row(REG_UNMAPPED_B, 64'hffff_ffff_ffff_ffff));
		add_row(smp_row(24'd12345));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_wr)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				push_sample(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
		end

		// random part: each phase reprograms the move, then streams samples
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				for (int r = REG_START_POS; r <= REG_DECEL_START; r++)
					write_reg(CFG_IDX_W'(r), rand_reg_data(CFG_IDX_W'(r)));
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					idx = CFG_IDX_W'($urandom_range(0, 7));
					write_reg(idx, rand_reg_data(idx));
				end
			end
			idle_mode = idle_mode_t'(ph % 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// receiver holds off while samples keep coming: pipe fills, input stalls
				if (ph == 4 && k == 20)
					hold_reqs <= hold_reqs + 1;
				// sender stops until the pipe has emptied
				if (ph == 5 && k == 30) begin
					in_valid <= 1'b0;
					while (expected_pts.size() != 0) @(posedge clk);
				end
				push_sample(pick_time(), 1'b0, '0);
			end
		end

		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		idle_mode = IDLE_NONE;
		while (expected_pts.size() != 0) @(posedge clk);
		// catch any stray beat after the last expected one
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (expected_pts.size() != 0)
			report_mismatch("missing beat", expected_pts[0].at, '0, expected_pts[0].pos);

		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
